FILE: sv/assert_macros.svh
// Assertion helpers shared by the tokenizer modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: sv/stt_pkg.sv
package stt_pkg;

  localparam int KIND_W  = 5;
  localparam int MAX_RES = 4;
  localparam int RIDX_W  = $clog2(MAX_RES);
  localparam int CNT_W   = RIDX_W + 1;
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int NUM_KW  = 5;

  typedef logic [KIND_W-1:0] kind_t;

  localparam kind_t K_IDENT   = 5'd5;
  localparam kind_t K_INT     = 5'd6;
  localparam kind_t K_VARARG  = 5'd7;
  localparam kind_t K_STRING  = 5'd8;
  localparam kind_t K_LPAREN  = 5'd9;
  localparam kind_t K_RPAREN  = 5'd10;
  localparam kind_t K_LBRACE  = 5'd11;
  localparam kind_t K_RBRACE  = 5'd12;
  localparam kind_t K_SEMI    = 5'd13;
  localparam kind_t K_COMMA   = 5'd14;
  localparam kind_t K_ASSIGN  = 5'd15;
  localparam kind_t K_PLUS    = 5'd16;
  localparam kind_t K_MINUS   = 5'd17;
  localparam kind_t K_ARROW   = 5'd18;
  localparam kind_t K_STAR    = 5'd19;
  localparam kind_t K_SLASH   = 5'd20;
  localparam kind_t K_COLON   = 5'd21;
  localparam kind_t K_END     = 5'd22;
  localparam kind_t K_UNKNOWN = 5'd23;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_GT     = 8'h3e;

  localparam logic [2:0] KW_LEN [NUM_KW] = '{3'd2, 3'd3, 3'd3, 3'd3, 3'd5};
  localparam logic [7:0] KW_TEXT [NUM_KW][5] = '{
    '{8'h66, 8'h6e, 8'h00, 8'h00, 8'h00},
    '{8'h6c, 8'h65, 8'h74, 8'h00, 8'h00},
    '{8'h72, 8'h65, 8'h74, 8'h00, 8'h00},
    '{8'h65, 8'h78, 8'h74, 8'h00, 8'h00},
    '{8'h63, 8'h6f, 8'h6e, 8'h73, 8'h74}
  };

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a)) || (c == 8'h5f);
  endfunction

  function automatic kind_t sym_kind(input logic [7:0] c);
    kind_t k;
    case (c)
      8'h28:   k = K_LPAREN;
      8'h29:   k = K_RPAREN;
      8'h7b:   k = K_LBRACE;
      8'h7d:   k = K_RBRACE;
      8'h3b:   k = K_SEMI;
      8'h2c:   k = K_COMMA;
      8'h3d:   k = K_ASSIGN;
      8'h2b:   k = K_PLUS;
      8'h2a:   k = K_STAR;
      8'h2f:   k = K_SLASH;
      8'h3a:   k = K_COLON;
      default: k = K_UNKNOWN;
    endcase
    return k;
  endfunction

endpackage

FILE: sv/source_text_tokenizer_top.sv
// Channel  | Ports                                              | Direction
// input    | push, full, in_ch, in_char_present, in_end_of_source | in
// result   | empty, pop, out_token_kind .. out_last_result      | out
//
// One source byte accepted per cycle while full is low; the lexer state updates in that cycle.
// Each byte yields zero to four token records, queued as one request.
// Records leave one per cycle while pop is held, so a burst of several records slows intake.
// The request queue holds four entries; full rises only when it fills.
// Synchronous active-low reset returns the lexer to position zero.
module source_text_tokenizer_top #(
  parameter int POS_WIDTH = 24,
  parameter int LEN_WIDTH = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  output logic                       full,
  input  logic [7:0]                 in_ch,
  input  logic                       in_char_present,
  input  logic                       in_end_of_source,
  output logic                       empty,
  input  logic                       pop,
  output logic [stt_pkg::KIND_W-1:0] out_token_kind,
  output logic [POS_WIDTH-1:0]       out_start_pos,
  output logic [LEN_WIDTH-1:0]       out_value_len,
  output logic [7:0]                 out_bad_char,
  output logic                       out_last_result
);

  localparam int BUN_W = stt_pkg::CNT_W +
                         stt_pkg::MAX_RES * (stt_pkg::KIND_W + POS_WIDTH + LEN_WIDTH + 8);

  stt_pkg::q_stat_t q_stat;
  logic             bund_push, q_pop;
  logic [BUN_W-1:0] bund, q_data;

  assign full = q_stat.full;

  stt_front #(.POS_W(POS_WIDTH), .LEN_W(LEN_WIDTH)) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .in_ch            (in_ch),
    .in_char_present  (in_char_present),
    .in_end_of_source (in_end_of_source),
    .q_stat           (q_stat),
    .bund_push        (bund_push),
    .bund             (bund)
  );

  stt_queue #(.W(BUN_W)) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (bund_push),
    .wr_data (bund),
    .rd_en   (q_pop),
    .rd_data (q_data),
    .stat    (q_stat)
  );

  stt_back #(.POS_W(POS_WIDTH), .LEN_W(LEN_WIDTH)) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_stat          (q_stat),
    .q_data          (q_data),
    .q_pop           (q_pop),
    .pop             (pop),
    .empty           (empty),
    .out_token_kind  (out_token_kind),
    .out_start_pos   (out_start_pos),
    .out_value_len   (out_value_len),
    .out_bad_char    (out_bad_char),
    .out_last_result (out_last_result)
  );

endmodule

FILE: sv/stt_queue.sv
`include "assert_macros.svh"

module stt_queue #(
  parameter int W = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [W-1:0]     wr_data,
  input  logic             rd_en,
  output logic [W-1:0]     rd_data,
  output stt_pkg::q_stat_t stat
);

  localparam int PW = stt_pkg::Q_PTR_W;

  logic [W-1:0]  mem_r [stt_pkg::Q_DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [PW:0]   cnt_r;
  logic          do_wr, do_rd;

  assign stat.full  = (cnt_r == (PW+1)'(stt_pkg::Q_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_wr      = wr_en && !stat.full;
  assign do_rd      = rd_en && !stat.empty;
  assign rd_data    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= wr_ptr_r + PW'(1);
      end
      if (do_rd) begin
        rd_ptr_r <= rd_ptr_r + PW'(1);
      end
      case ({do_wr, do_rd})
        2'b10:   cnt_r <= cnt_r + (PW+1)'(1);
        2'b01:   cnt_r <= cnt_r - (PW+1)'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  `ASSERT_CLK(a_q_bound, cnt_r <= (PW+1)'(stt_pkg::Q_DEPTH), "queue count beyond depth")

endmodule

FILE: sv/stt_front.sv
`include "assert_macros.svh"

module stt_front #(
  parameter int POS_W = 24,
  parameter int LEN_W = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [7:0]       in_ch,
  input  logic             in_char_present,
  input  logic             in_end_of_source,
  input  stt_pkg::q_stat_t q_stat,
  output logic             bund_push,
  output logic [stt_pkg::CNT_W+stt_pkg::MAX_RES*(stt_pkg::KIND_W+POS_W+LEN_W+8)-1:0] bund
);

  localparam int REC_W = stt_pkg::KIND_W + POS_W + LEN_W + 8;
  localparam int NK    = stt_pkg::NUM_KW;

  localparam logic [1:0] M_IDLE   = 2'd0;
  localparam logic [1:0] M_IDENT  = 2'd1;
  localparam logic [1:0] M_INT    = 2'd2;
  localparam logic [1:0] M_STRING = 2'd3;

  logic [1:0]       mode_r, mode_nxt;
  logic [POS_W-1:0] byte_index_r, byte_index_nxt;
  logic [POS_W-1:0] tok_start_r, tok_start_nxt;
  logic [LEN_W-1:0] tok_len_r, tok_len_nxt;
  logic [NK-1:0]    kw_cand_r, kw_cand_nxt;
  logic             esc_r, esc_nxt;
  logic [1:0]       dots_r, dots_nxt;
  logic             minus_r, minus_nxt;
  logic             acc;
  logic [stt_pkg::CNT_W-1:0] n_v;
  logic [REC_W-1:0] rec_v [stt_pkg::MAX_RES];

  function automatic logic [REC_W-1:0] mk_rec(input stt_pkg::kind_t k,
                                              input logic [POS_W-1:0] p,
                                              input logic [LEN_W-1:0] l,
                                              input logic [7:0] b);
    return {k, p, l, b};
  endfunction

  function automatic logic [POS_W-1:0] pos_inc(input logic [POS_W-1:0] v);
    return (v == {POS_W{1'b1}}) ? v : v + POS_W'(1);
  endfunction

  function automatic logic [LEN_W-1:0] len_inc(input logic [LEN_W-1:0] v);
    return (v == {LEN_W{1'b1}}) ? v : v + LEN_W'(1);
  endfunction

  function automatic logic [NK-1:0] kw_hit(input logic [7:0] c, input logic [LEN_W-1:0] l);
    logic [NK-1:0] h;
    for (int k = 0; k < NK; k++) begin
      h[k] = (l < {{(LEN_W-3){1'b0}}, stt_pkg::KW_LEN[k]}) &&
             (stt_pkg::KW_TEXT[k][l[2:0]] == c);
    end
    return h;
  endfunction

  function automatic stt_pkg::kind_t word_kind(input logic [1:0] m, input logic [NK-1:0] cand,
                                               input logic [LEN_W-1:0] l);
    stt_pkg::kind_t k;
    k = (m == M_INT) ? stt_pkg::K_INT : stt_pkg::K_IDENT;
    if (m == M_IDENT) begin
      for (int i = NK - 1; i >= 0; i--) begin
        if (cand[i] && (l == {{(LEN_W-3){1'b0}}, stt_pkg::KW_LEN[i]})) begin
          k = stt_pkg::KIND_W'(i);
        end
      end
    end
    return k;
  endfunction

  always_comb begin
    logic do_start;
    stt_pkg::kind_t sk;
    mode_nxt       = mode_r;
    byte_index_nxt = byte_index_r;
    tok_start_nxt  = tok_start_r;
    tok_len_nxt    = tok_len_r;
    kw_cand_nxt    = kw_cand_r;
    esc_nxt        = esc_r;
    dots_nxt       = dots_r;
    minus_nxt      = minus_r;
    n_v            = '0;
    do_start       = 1'b0;
    sk             = stt_pkg::K_UNKNOWN;
    for (int i = 0; i < stt_pkg::MAX_RES; i++) begin
      rec_v[i] = '0;
    end

    if (in_char_present) begin
      do_start = 1'b1;
      case (mode_nxt)
        M_STRING: begin
          do_start = 1'b0;
          if (esc_nxt) begin
            esc_nxt     = 1'b0;
            tok_len_nxt = len_inc(tok_len_nxt);
          end else if (in_ch == stt_pkg::CH_QUOTE) begin
            rec_v[n_v[stt_pkg::RIDX_W-1:0]] = mk_rec(stt_pkg::K_STRING, tok_start_nxt,
                                                     tok_len_nxt, 8'd0);
            n_v      = n_v + stt_pkg::CNT_W'(1);
            mode_nxt = M_IDLE;
          end else begin
            if (in_ch == stt_pkg::CH_BSLASH) begin
              esc_nxt = 1'b1;
            end
            tok_len_nxt = len_inc(tok_len_nxt);
          end
        end
        M_IDENT, M_INT: begin
          if (stt_pkg::is_digit(in_ch) || (mode_nxt == M_IDENT && stt_pkg::is_alpha(in_ch))) begin
            kw_cand_nxt = kw_cand_nxt & kw_hit(in_ch, tok_len_nxt);
            tok_len_nxt = len_inc(tok_len_nxt);
            do_start    = 1'b0;
          end else begin
            rec_v[n_v[stt_pkg::RIDX_W-1:0]] = mk_rec(word_kind(mode_nxt, kw_cand_nxt, tok_len_nxt),
                                                     tok_start_nxt, tok_len_nxt, 8'd0);
            n_v      = n_v + stt_pkg::CNT_W'(1);
            mode_nxt = M_IDLE;
          end
        end
        default: begin
          if (dots_nxt != 2'd0) begin
            if (in_ch == stt_pkg::CH_DOT) begin
              do_start = 1'b0;
              if (dots_nxt >= 2'd2) begin
                rec_v[n_v[stt_pkg::RIDX_W-1:0]] = mk_rec(stt_pkg::K_VARARG, tok_start_nxt,
                                                         LEN_W'(3), 8'd0);
                n_v      = n_v + stt_pkg::CNT_W'(1);
                dots_nxt = 2'd0;
              end else begin
                dots_nxt = 2'd2;
              end
            end else begin
              rec_v[n_v[stt_pkg::RIDX_W-1:0]] = mk_rec(stt_pkg::K_UNKNOWN, tok_start_nxt,
                                                       LEN_W'(1), stt_pkg::CH_DOT);
              n_v = n_v + stt_pkg::CNT_W'(1);
              if (dots_nxt >= 2'd2) begin
                rec_v[n_v[stt_pkg::RIDX_W-1:0]] = mk_rec(stt_pkg::K_UNKNOWN,
                                                         pos_inc(tok_start_nxt),
                                                         LEN_W'(1), stt_pkg::CH_DOT);
                n_v = n_v + stt_pkg::CNT_W'(1);
              end
              dots_nxt = 2'd0;
            end
          end else if (minus_nxt) begin
            minus_nxt = 1'b0;
            if (in_ch == stt_pkg::CH_GT) begin
              rec_v[n_v[stt_pkg::RIDX_W-1:0]] = mk_rec(stt_pkg::K_ARROW, tok_start_nxt,
                                                       LEN_W'(2), 8'd0);
              do_start = 1'b0;
            end else begin
              rec_v[n_v[stt_pkg::RIDX_W-1:0]] = mk_rec(stt_pkg::K_MINUS, tok_start_nxt,
                                                       LEN_W'(1), 8'd0);
            end
            n_v = n_v + stt_pkg::CNT_W'(1);
          end
        end
      endcase

      if (do_start && !stt_pkg::is_space(in_ch)) begin
        tok_start_nxt = byte_index_r;
        if (stt_pkg::is_alpha(in_ch)) begin
          mode_nxt    = M_IDENT;
          tok_len_nxt = LEN_W'(1);
          kw_cand_nxt = kw_hit(in_ch, '0);
        end else if (stt_pkg::is_digit(in_ch)) begin
          mode_nxt    = M_INT;
          tok_len_nxt = LEN_W'(1);
        end else if (in_ch == stt_pkg::CH_QUOTE) begin
          mode_nxt    = M_STRING;
          tok_len_nxt = '0;
          esc_nxt     = 1'b0;
        end else if (in_ch == stt_pkg::CH_DOT) begin
          dots_nxt = 2'd1;
        end else if (in_ch == stt_pkg::CH_MINUS) begin
          minus_nxt = 1'b1;
        end else begin
          sk = stt_pkg::sym_kind(in_ch);
          rec_v[n_v[stt_pkg::RIDX_W-1:0]] = mk_rec(sk, byte_index_r, LEN_W'(1),
                                                   (sk == stt_pkg::K_UNKNOWN) ? in_ch : 8'd0);
          n_v = n_v + stt_pkg::CNT_W'(1);
        end
      end
      byte_index_nxt = pos_inc(byte_index_r);
    end

    if (in_end_of_source) begin
      if (mode_nxt == M_IDENT || mode_nxt == M_INT) begin
        rec_v[n_v[stt_pkg::RIDX_W-1:0]] = mk_rec(word_kind(mode_nxt, kw_cand_nxt, tok_len_nxt),
                                                 tok_start_nxt, tok_len_nxt, 8'd0);
        n_v = n_v + stt_pkg::CNT_W'(1);
      end else if (mode_nxt == M_STRING) begin
        rec_v[n_v[stt_pkg::RIDX_W-1:0]] = mk_rec(stt_pkg::K_STRING, tok_start_nxt,
                                                 tok_len_nxt, 8'd0);
        n_v = n_v + stt_pkg::CNT_W'(1);
      end else if (dots_nxt != 2'd0) begin
        rec_v[n_v[stt_pkg::RIDX_W-1:0]] = mk_rec(stt_pkg::K_UNKNOWN, tok_start_nxt,
                                                 LEN_W'(1), stt_pkg::CH_DOT);
        n_v = n_v + stt_pkg::CNT_W'(1);
        if (dots_nxt >= 2'd2) begin
          rec_v[n_v[stt_pkg::RIDX_W-1:0]] = mk_rec(stt_pkg::K_UNKNOWN, pos_inc(tok_start_nxt),
                                                   LEN_W'(1), stt_pkg::CH_DOT);
          n_v = n_v + stt_pkg::CNT_W'(1);
        end
      end else if (minus_nxt) begin
        rec_v[n_v[stt_pkg::RIDX_W-1:0]] = mk_rec(stt_pkg::K_MINUS, tok_start_nxt,
                                                 LEN_W'(1), 8'd0);
        n_v = n_v + stt_pkg::CNT_W'(1);
      end
      rec_v[n_v[stt_pkg::RIDX_W-1:0]] = mk_rec(stt_pkg::K_END, byte_index_nxt, '0, 8'd0);
      n_v            = n_v + stt_pkg::CNT_W'(1);
      mode_nxt       = M_IDLE;
      byte_index_nxt = '0;
      tok_start_nxt  = '0;
      tok_len_nxt    = '0;
      kw_cand_nxt    = '1;
      esc_nxt        = 1'b0;
      dots_nxt       = 2'd0;
      minus_nxt      = 1'b0;
    end
  end

  assign acc       = push && !q_stat.full;
  assign bund_push = acc && (n_v != '0);
  assign bund      = {n_v, rec_v[3], rec_v[2], rec_v[1], rec_v[0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= M_IDLE;
      byte_index_r <= '0;
      tok_start_r  <= '0;
      tok_len_r    <= '0;
      kw_cand_r    <= '1;
      esc_r        <= 1'b0;
      dots_r       <= 2'd0;
      minus_r      <= 1'b0;
    end else if (acc) begin
      mode_r       <= mode_nxt;
      byte_index_r <= byte_index_nxt;
      tok_start_r  <= tok_start_nxt;
      tok_len_r    <= tok_len_nxt;
      kw_cand_r    <= kw_cand_nxt;
      esc_r        <= esc_nxt;
      dots_r       <= dots_nxt;
      minus_r      <= minus_nxt;
    end
  end

  `ASSERT_CLK(a_eos_restarts, (acc && in_end_of_source) |=> ((byte_index_r == '0) && (mode_r == M_IDLE)), "state not cleared after end of source")
  `ASSERT_CLK(a_eos_emits, (acc && in_end_of_source) |-> bund_push, "end of source without a request")

endmodule

FILE: sv/stt_back.sv
`include "assert_macros.svh"

module stt_back #(
  parameter int POS_W = 24,
  parameter int LEN_W = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  stt_pkg::q_stat_t q_stat,
  input  logic [stt_pkg::CNT_W+stt_pkg::MAX_RES*(stt_pkg::KIND_W+POS_W+LEN_W+8)-1:0] q_data,
  output logic             q_pop,
  input  logic             pop,
  output logic             empty,
  output logic [stt_pkg::KIND_W-1:0] out_token_kind,
  output logic [POS_W-1:0] out_start_pos,
  output logic [LEN_W-1:0] out_value_len,
  output logic [7:0]       out_bad_char,
  output logic             out_last_result
);

  localparam int REC_W = stt_pkg::KIND_W + POS_W + LEN_W + 8;
  localparam int BUN_W = stt_pkg::CNT_W + stt_pkg::MAX_RES * REC_W;

  logic [BUN_W-1:0]            cur_r;
  logic                        cur_valid_r;
  logic [stt_pkg::RIDX_W-1:0]  idx_r;
  logic [stt_pkg::CNT_W-1:0]   cnt;
  logic [REC_W-1:0]            rec;
  logic                        take, at_last;

  assign cnt     = cur_r[BUN_W-1 -: stt_pkg::CNT_W];
  assign rec     = cur_r[idx_r*REC_W +: REC_W];
  assign at_last = ({1'b0, idx_r} + stt_pkg::CNT_W'(1)) == cnt;
  assign empty   = !cur_valid_r;
  assign take    = cur_valid_r && pop;
  assign q_pop   = !q_stat.empty && (!cur_valid_r || (take && at_last));

  assign out_token_kind  = rec[REC_W-1 -: stt_pkg::KIND_W];
  assign out_start_pos   = rec[LEN_W+8 +: POS_W];
  assign out_value_len   = rec[8 +: LEN_W];
  assign out_bad_char    = rec[7:0];
  assign out_last_result = at_last;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= '0;
    end else if (q_pop) begin
      cur_valid_r <= 1'b1;
      idx_r       <= '0;
    end else if (take && at_last) begin
      cur_valid_r <= 1'b0;
    end else if (take) begin
      idx_r <= idx_r + stt_pkg::RIDX_W'(1);
    end
  end

  `ASSERT_CLK(a_idx_in_bundle, cur_valid_r |-> ({1'b0, idx_r} < cnt), "result index beyond bundle count")

endmodule
